[design/idl_pkg.sv]
// Shared types, codes and helpers for the integer dense layer.
package idl_pkg;

    localparam int IN_MAX_DEF    = 16;
    localparam int OUT_MAX_DEF   = 16;
    localparam int BATCH_MAX_DEF = 8;
    localparam logic [4:0] RESULT_CAP = 5'd16;

    typedef enum logic [2:0] {
        OP_WEIGHT = 3'd0,
        OP_BIAS   = 3'd1,
        OP_FWD    = 3'd2,
        OP_BWD    = 3'd3,
        OP_UPDATE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_FWD = 2'd0,
        KIND_GIN = 2'd1,
        KIND_UPD = 2'd2
    } t_kind;

    localparam logic [1:0] CFG_INPUTS  = 2'd0;
    localparam logic [1:0] CFG_OUTPUTS = 2'd1;
    localparam logic [1:0] CFG_RATE    = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         batch_row;
        logic [3:0]         neuron;
        logic [3:0]         column;
        logic signed [31:0] operand;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         position;
        logic signed [31:0] result_value;
        logic               last_of_run;
    } t_out;

    typedef struct packed {
        t_op         op;
        logic [2:0]  batch_row;
        logic [3:0]  neuron;
        logic [3:0]  column;
        logic [31:0] operand;
        logic [4:0]  ni;
        logic [4:0]  no;
        logic        emit;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } t_back_state;

    // Count register as used: zero reads as one, large values saturate.
    function automatic logic [4:0] eff_count(input logic [4:0] r, input int limit);
        logic [4:0] n;
        n = r;
        if (n == 5'd0) n = 5'd1;
        if (int'(n) > limit) n = 5'(limit);
        if (n > RESULT_CAP) n = RESULT_CAP;
        return n;
    endfunction

endpackage

[design/idl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module idl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/idl_fifo.sv]
// Small register queue used between the front, the back and the result port.
module idl_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    T               r_mem [DEPTH];
    logic [PW-1:0]  r_head, r_tail;
    logic [PW:0]    r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (do_push && !do_pop) r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_data;
        end
    end
endmodule

[design/idl_front.sv]
// Front end: configuration registers, item checking and command generation.
module idl_front #(
    parameter int IN_MAX    = idl_pkg::IN_MAX_DEF,
    parameter int OUT_MAX   = idl_pkg::OUT_MAX_DEF,
    parameter int BATCH_MAX = idl_pkg::BATCH_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_push,
    input  idl_pkg::t_in  i_item,
    input  logic          i_hold,
    output logic          o_full,
    output logic          o_cmd_push,
    output idl_pkg::t_cmd o_cmd,
    input  logic          i_cmd_full,
    output logic [31:0]   o_learn_rate
);
    import idl_pkg::*;

    logic [4:0]  r_input_count, r_output_count;
    logic [31:0] r_learn_rate;
    logic [4:0]  ni, no;
    logic        keep, emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= 5'd16;
            r_output_count <= 5'd16;
            r_learn_rate   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INPUTS:  r_input_count  <= i_cfg_data[4:0];
                CFG_OUTPUTS: r_output_count <= i_cfg_data[4:0];
                CFG_RATE:    r_learn_rate   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ni = eff_count(r_input_count, IN_MAX);
    assign no = eff_count(r_output_count, OUT_MAX);

    // Items with out-of-range indices or unknown operations are dropped here.
    always_comb begin
        keep = 1'b0;
        emit = 1'b0;
        unique case (i_item.operation)
            OP_WEIGHT: keep = (int'(i_item.neuron) < OUT_MAX) && (int'(i_item.column) < IN_MAX);
            OP_BIAS:   keep = (int'(i_item.neuron) < OUT_MAX);
            OP_FWD: begin
                keep = (int'(i_item.batch_row) < BATCH_MAX) && ({1'b0, i_item.column} < ni);
                emit = ({1'b0, i_item.column} == ni - 5'd1);
            end
            OP_BWD: begin
                keep = (int'(i_item.batch_row) < BATCH_MAX) && ({1'b0, i_item.neuron} < no);
                emit = ({1'b0, i_item.neuron} == no - 5'd1);
            end
            OP_UPDATE: begin
                keep = 1'b1;
                emit = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_full       = i_cmd_full || i_hold;
    assign o_cmd_push   = i_push && !o_full && keep;
    assign o_learn_rate = r_learn_rate;

    always_comb begin
        o_cmd.op        = t_op'(i_item.operation);
        o_cmd.batch_row = i_item.batch_row;
        o_cmd.neuron    = i_item.neuron;
        o_cmd.column    = i_item.column;
        o_cmd.operand   = i_item.operand;
        o_cmd.ni        = ni;
        o_cmd.no        = no;
        o_cmd.emit      = emit;
    end
endmodule

[design/idl_back.sv]
// Back end: sequencer with one multiply pipeline over the weight, input and gradient stores.
module idl_back #(
    parameter int IN_MAX    = idl_pkg::IN_MAX_DEF,
    parameter int OUT_MAX   = idl_pkg::OUT_MAX_DEF,
    parameter int BATCH_MAX = idl_pkg::BATCH_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  idl_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic [31:0]   i_learn_rate,
    output logic          o_clearing,
    output logic          o_res_push,
    output idl_pkg::t_out o_res,
    input  logic          i_res_full
);
    import idl_pkg::*;

    localparam int WN = OUT_MAX * IN_MAX;
    localparam int SN = BATCH_MAX * IN_MAX;
    localparam int UN = WN + OUT_MAX;
    localparam int WA = (WN > 1) ? $clog2(WN) : 1;
    localparam int SA = (SN > 1) ? $clog2(SN) : 1;
    localparam int CW = $clog2(UN + 1);
    localparam int BW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int IW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;

    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [CW-1:0] r_issue, r_limit, r_i1, r_i2, r_i3;
    logic          r_v1, r_v2, r_v3;
    logic [4:0]    r_ecnt, r_etotal;
    logic [WA-1:0] r_clr;

    logic [31:0] r_bias  [OUT_MAX];
    logic [31:0] r_bgrad [OUT_MAX];
    logic [31:0] r_facc  [OUT_MAX];
    logic [31:0] r_gacc  [IN_MAX];

    logic signed [63:0] r_pa;
    logic [31:0] r_pb, r_pc, r_old, r_wv, r_wv2, r_q;

    logic [31:0] w_rdata, s_rdata, g_rdata;
    logic        w_we, s_we, g_we;
    logic [WA-1:0] w_waddr, w_raddr, g_waddr;
    logic [SA-1:0] s_waddr, s_raddr;
    logic [31:0] w_wdata, g_wdata;

    logic          issue, drained, is_upd, last_emit;
    logic [CW-1:0] ui1, ui3;
    logic [BW-1:0] bidx, bgidx, fidx;
    logic [IW-1:0] gidx;
    logic [31:0]   b_rd, bg_rd, f_rd, gacc_rd;
    logic signed [31:0] upd_src;
    logic [63:0]   rnd_sum;

    assign is_upd    = (r_cmd.op == OP_UPDATE);
    assign issue     = (r_state == ST_RUN) && (r_issue < r_limit);
    assign drained   = (r_issue == r_limit) && !r_v1 && !r_v2 && !r_v3;
    assign last_emit = (r_ecnt == r_etotal - 5'd1);
    assign o_clearing = (r_state == ST_CLEAR);

    assign ui1   = r_i1 - CW'(WN);
    assign ui3   = r_i3 - CW'(WN);
    assign bidx  = is_upd ? ui1[BW-1:0] : r_i2[BW-1:0];
    assign bgidx = (r_state == ST_IDLE) ? BW'(i_cmd.neuron) : ui1[BW-1:0];
    assign fidx  = (r_state == ST_EMIT) ? BW'(r_ecnt) : r_i2[BW-1:0];
    assign gidx  = (r_state == ST_EMIT) ? IW'(r_ecnt) : r_i2[IW-1:0];
    assign b_rd    = r_bias[bidx];
    assign bg_rd   = r_bgrad[bgidx];
    assign f_rd    = r_facc[fidx];
    assign gacc_rd = r_gacc[gidx];

    // Read addresses follow the issue counter; data returns in the next cycle.
    always_comb begin
        unique case (r_cmd.op)
            OP_FWD:  w_raddr = WA'(int'(r_issue) * IN_MAX + int'(r_cmd.column));
            OP_BWD:  w_raddr = WA'(int'(r_cmd.neuron) * IN_MAX + int'(r_issue));
            default: w_raddr = r_issue[WA-1:0];
        endcase
    end
    assign s_raddr = SA'(int'(r_cmd.batch_row) * IN_MAX + int'(r_issue));

    assign w_we    = ((r_state == ST_RUN) && (r_cmd.op == OP_WEIGHT)) ||
                     (r_v3 && is_upd && (int'(r_i3) < WN));
    assign w_waddr = (r_cmd.op == OP_WEIGHT) ?
                     WA'(int'(r_cmd.neuron) * IN_MAX + int'(r_cmd.column)) : r_i3[WA-1:0];
    assign w_wdata = (r_cmd.op == OP_WEIGHT) ? r_cmd.operand : r_wv2 + r_q;

    assign s_we    = (r_state == ST_IDLE) && i_cmd_valid && (i_cmd.op == OP_FWD);
    assign s_waddr = SA'(int'(i_cmd.batch_row) * IN_MAX + int'(i_cmd.column));

    assign g_we    = o_clearing || (r_v2 && (r_cmd.op == OP_BWD));
    assign g_waddr = o_clearing ? r_clr :
                     WA'(int'(r_cmd.neuron) * IN_MAX + int'(r_i2));
    assign g_wdata = o_clearing ? 32'd0 :
                     ((r_cmd.batch_row == 3'd0) ? r_pc : r_old + r_pc);

    idl_ram #(.WIDTH(32), .DEPTH(WN)) u_weight (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    idl_ram #(.WIDTH(32), .DEPTH(SN)) u_saved (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(i_cmd.operand),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    idl_ram #(.WIDTH(32), .DEPTH(WN)) u_wgrad (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(w_raddr), .o_rdata(g_rdata)
    );

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == WA'(WN - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (drained) n_state = r_cmd.emit ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                o_res_push = !i_res_full;
                if (!i_res_full && last_emit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_res.kind         = KIND_UPD;
        o_res.position     = 4'd0;
        o_res.result_value = '0;
        o_res.last_of_run  = last_emit;
        case (r_cmd.op)
            OP_FWD: begin
                o_res.kind         = KIND_FWD;
                o_res.position     = r_ecnt[3:0];
                o_res.result_value = f_rd;
            end
            OP_BWD: begin
                o_res.kind         = KIND_GIN;
                o_res.position     = r_ecnt[3:0];
                o_res.result_value = gacc_rd;
            end
            default: ;
        endcase
    end

    assign upd_src = (int'(r_i1) < WN) ? g_rdata : bg_rd;
    // Truncation toward zero: add 2^16-1 to negative products before the shift.
    assign rnd_sum = r_pa + {48'd0, {16{r_pa[63]}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_issue <= '0;
            r_limit <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_ecnt  <= '0;
            for (int k = 0; k < OUT_MAX; k++) r_bgrad[k] <= '0;
        end else begin
            r_state <= n_state;
            if (o_clearing) r_clr <= r_clr + 1'b1;
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (issue) r_issue <= r_issue + 1'b1;
            if (o_res_push) r_ecnt <= r_ecnt + 5'd1;
            if (o_cmd_pop) begin
                r_issue <= '0;
                r_ecnt  <= '0;
                case (i_cmd.op)
                    OP_FWD:    r_limit <= CW'(i_cmd.no);
                    OP_BWD:    r_limit <= CW'(i_cmd.ni);
                    OP_UPDATE: r_limit <= CW'(UN);
                    default:   r_limit <= '0;
                endcase
                if (i_cmd.op == OP_BWD) begin
                    r_bgrad[bgidx] <= (i_cmd.batch_row == 3'd0) ?
                                      i_cmd.operand : bg_rd + i_cmd.operand;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            unique case (i_cmd.op)
                OP_FWD:  r_etotal <= i_cmd.no;
                OP_BWD:  r_etotal <= i_cmd.ni;
                default: r_etotal <= 5'd1;
            endcase
        end
        r_i1 <= r_issue;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        if ((r_state == ST_RUN) && (r_cmd.op == OP_BIAS)) begin
            r_bias[BW'(r_cmd.neuron)] <= r_cmd.operand;
        end
        // Stage one: products of the returned store data.
        if (r_v1) begin
            r_pb  <= 32'(w_rdata * r_cmd.operand);
            r_pc  <= 32'(s_rdata * r_cmd.operand);
            r_old <= g_rdata;
            r_pa  <= upd_src * $signed(i_learn_rate);
            r_wv  <= (int'(r_i1) < WN) ? w_rdata : b_rd;
        end
        // Stage two: accumulate, or scale the update step.
        if (r_v2) begin
            r_q   <= rnd_sum[47:16];
            r_wv2 <= r_wv;
            if (r_cmd.op == OP_FWD) begin
                r_facc[fidx] <= (r_cmd.column == 4'd0) ? b_rd + r_pb : f_rd + r_pb;
            end
            if (r_cmd.op == OP_BWD) begin
                r_gacc[gidx] <= (r_cmd.neuron == 4'd0) ? r_pb : gacc_rd + r_pb;
            end
        end
        if (r_v3 && is_upd && (int'(r_i3) >= WN)) begin
            r_bias[ui3[BW-1:0]] <= r_wv2 + r_q;
        end
    end
endmodule

[design/integer_dense_layer_train.sv]
// Top level of the integer dense layer with forward, backward and update passes.
//
// Items enter through a queue port: a beat is taken when push is high and full low.
// Results leave through a queue port: the oldest result shows while empty is low
// and is taken when pop is high. Configuration is a plain write port (enable,
// index, data) used while the block is idle.
// A front stage checks each item and queues a command; a back sequencer runs
// commands through one multiply pipeline, one store entry per cycle.
// A forward element reads output_count weights, a backward element input_count,
// through the single read port of the weight store and a three stage pipeline;
// the completing element then emits one result per cycle while the result queue
// is not full. An update walks all OUT_MAX*IN_MAX weights and OUT_MAX biases
// and returns one result. After reset the weight gradient store is zeroed,
// during which full stays high. When the receiver stalls, results wait in a
// small queue, the back end holds, and then full rises.
module integer_dense_layer_train #(
    parameter int IN_MAX    = idl_pkg::IN_MAX_DEF,
    parameter int OUT_MAX   = idl_pkg::OUT_MAX_DEF,
    parameter int BATCH_MAX = idl_pkg::BATCH_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  idl_pkg::t_in  i_item,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output idl_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import idl_pkg::*;

    t_cmd  front_cmd, back_cmd;
    t_out  back_res;
    logic  cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic  res_push, res_full, clearing;
    logic [31:0] learn_rate;

    idl_front #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX), .BATCH_MAX(BATCH_MAX)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_push(push), .i_item(i_item), .i_hold(clearing), .o_full(full),
        .o_cmd_push(cmd_push), .o_cmd(front_cmd), .i_cmd_full(cmd_full),
        .o_learn_rate(learn_rate)
    );

    idl_fifo #(.T(t_cmd), .DEPTH(2)) u_cmd_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(cmd_push), .i_data(front_cmd), .o_full(cmd_full),
        .i_pop(cmd_pop), .o_data(back_cmd), .o_empty(cmd_empty)
    );

    idl_back #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX), .BATCH_MAX(BATCH_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(!cmd_empty), .i_cmd(back_cmd), .o_cmd_pop(cmd_pop),
        .i_learn_rate(learn_rate), .o_clearing(clearing),
        .o_res_push(res_push), .o_res(back_res), .i_res_full(res_full)
    );

    idl_fifo #(.T(t_out), .DEPTH(4)) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(res_push), .i_data(back_res), .o_full(res_full),
        .i_pop(pop), .o_data(o_result), .o_empty(empty)
    );
endmodule
